>>> rtl/core/rgbc_lux_cct_calibrator_assert.svh
// ----------------------------------------------------------------------------
// rgbc calibrator assertion macros
// shared property forms for the port-level checks
// ----------------------------------------------------------------------------
`ifndef RGBC_LUX_CCT_CALIBRATOR_ASSERT_SVH
`define RGBC_LUX_CCT_CALIBRATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RGBC_CAL_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rgbc calibrator check failed");

// next-cycle implication, disabled during reset
`define RGBC_CAL_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rgbc calibrator check failed");

`endif

>>> rtl/core/rgbc_cal_pkg.sv
// ----------------------------------------------------------------------------
// rgbc calibrator package
// widths, constants and the word types shared by the calibrator modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rgbc_cal_pkg;

    // port widths
    localparam int CH_W       = 16;
    localparam int CORR_W     = 18;
    localparam int OUT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // internal widths
    localparam int STEPS_W    = 8;
    localparam int TIME_W     = 20;
    localparam int SHIFT_W    = 3;
    localparam int SUM_W      = 19;
    localparam int WSUM_W     = 23;
    localparam int MAG_W      = 22;
    localparam int DVD_W      = 43;
    localparam int DVS_W      = 27;
    localparam int DIV_STAGES = DVD_W;
    localparam int CPL_FRAC   = 16;

    // counts per lux by reciprocal multiplication
    localparam int CPLX_W      = 27;
    localparam int CPLQ_W      = 26;
    localparam int CPL_NUM_W   = CPLX_W + CPL_FRAC;
    localparam int RECIP_W     = 31;
    localparam int RECIP_SHIFT = 32;
    localparam int CPL_PROD_W  = 58;
    localparam int DENOM_W     = 18;

    // arithmetic constants
    localparam logic [TIME_W-1:0] TIME_STEP_UNITS = TIME_W'(281);
    localparam logic [TIME_W-1:0] LONG_WAIT_MULT  = TIME_W'(12);
    localparam logic [DVS_W-1:0]  LUX_DVS_SCALE   = DVS_W'(100);
    localparam logic [DVD_W-1:0]  LUX_DVD_SCALE   = DVD_W'(2185120);
    localparam logic [DENOM_W-1:0] CPL_DENOM      = DENOM_W'(136570);
    // floor(2^48 / 136570), estimate low by at most one
    localparam logic [RECIP_W-1:0] CPL_RECIP      = RECIP_W'(2061030802);
    localparam logic [WSUM_W-1:0] BLUE_WEIGHT     = WSUM_W'(29);
    localparam logic signed [OUT_W-1:0] CCT_BLUE_GAIN = 32'sd4520;
    localparam logic signed [OUT_W-1:0] CCT_OFFSET    = 32'sd1804;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INTEG_STEPS = 2'd0,
        REG_LONG_WAIT   = 2'd1,
        REG_GAIN_INDEX  = 2'd2,
        REG_GAIN_RANGE  = 2'd3
    } cfg_reg_t;

    // word handed from the front end to the back end
    typedef struct packed {
        logic signed [CORR_W-1:0] infrared;
        logic signed [CORR_W-1:0] red_corr;
        logic signed [CORR_W-1:0] green_corr;
        logic signed [CORR_W-1:0] blue_corr;
        logic signed [CORR_W-1:0] clear_corr;
        logic                     red_zero;
        logic                     lux_neg;
        logic [DVD_W-1:0]         lux_dvd;
        logic [DVS_W-1:0]         lux_dvs;
        logic [CPLX_W-1:0]        cpl_x;
        logic [CPLQ_W-1:0]        cpl_est;
        logic [SHIFT_W-1:0]       gain_shift;
        logic signed [OUT_W-1:0]  cct_num;
    } work_t;

    // fields that ride alongside the dividers
    typedef struct packed {
        logic signed [CORR_W-1:0] infrared;
        logic signed [CORR_W-1:0] red_corr;
        logic signed [CORR_W-1:0] green_corr;
        logic signed [CORR_W-1:0] blue_corr;
        logic signed [CORR_W-1:0] clear_corr;
        logic                     red_zero;
        logic                     lux_neg;
        logic                     cct_neg;
        logic [OUT_W-1:0]         cpl;
        logic [SHIFT_W-1:0]       gain_shift;
    } side_t;

endpackage

>>> rtl/core/rgbc_lux_cct_calibrator.sv
// ----------------------------------------------------------------------------
// rgbc lux and colour temperature calibrator
// infrared correction, counts per lux, lux and colour temperature per sample
// ----------------------------------------------------------------------------
//   channel | handshake            | carries
//   cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in_valid/in_ready    | raw clear, red, green, blue
//   out     | out_valid/out_ready  | infrared, corrected channels, cpl, lux, cct
//
// one word per cycle sustained while the output is taken; the path runs through
// the two front stages, the queue, the 43 one-bit divider stages and the output reg.
// reset loads the register defaults; cfg_ready is always high.
// a stalled output holds the back end; the queue lets the front end run on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgbc_lux_cct_calibrator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rgbc_cal_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rgbc_cal_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [rgbc_cal_pkg::CH_W-1:0]        raw_clear,
    input  logic [rgbc_cal_pkg::CH_W-1:0]        raw_red,
    input  logic [rgbc_cal_pkg::CH_W-1:0]        raw_green,
    input  logic [rgbc_cal_pkg::CH_W-1:0]        raw_blue,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [rgbc_cal_pkg::CORR_W-1:0] infrared,
    output logic signed [rgbc_cal_pkg::CORR_W-1:0] red_corrected,
    output logic signed [rgbc_cal_pkg::CORR_W-1:0] green_corrected,
    output logic signed [rgbc_cal_pkg::CORR_W-1:0] blue_corrected,
    output logic signed [rgbc_cal_pkg::CORR_W-1:0] clear_corrected,
    output logic [rgbc_cal_pkg::OUT_W-1:0]         counts_per_lux,
    output logic signed [rgbc_cal_pkg::OUT_W-1:0]  lux,
    output logic signed [rgbc_cal_pkg::OUT_W-1:0]  colour_temp,
    output logic                                   red_zero
);
    import rgbc_cal_pkg::*;

    logic  f_valid;
    logic  f_ready;
    work_t f_word;
    logic  q_valid;
    logic  q_pop;
    work_t q_word;

    // front end
    rgbc_cal_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .raw_clear  (raw_clear),
        .raw_red    (raw_red),
        .raw_green  (raw_green),
        .raw_blue   (raw_blue),
        .work_valid (f_valid),
        .work_ready (f_ready),
        .work       (f_word)
    );

    // decoupling queue
    rgbc_cal_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_word  (f_word),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_word   (q_word)
    );

    // back end
    rgbc_cal_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .work_valid      (q_valid),
        .work_pop        (q_pop),
        .work            (q_word),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .infrared        (infrared),
        .red_corrected   (red_corrected),
        .green_corrected (green_corrected),
        .blue_corrected  (blue_corrected),
        .clear_corrected (clear_corrected),
        .counts_per_lux  (counts_per_lux),
        .lux             (lux),
        .colour_temp     (colour_temp),
        .red_zero        (red_zero)
    );

endmodule

>>> rtl/core/rgbc_cal_front.sv
// ----------------------------------------------------------------------------
// rgbc calibrator front end
// holds the settings, takes raw words and prepares the divider operands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgbc_cal_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rgbc_cal_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rgbc_cal_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [rgbc_cal_pkg::CH_W-1:0]        raw_clear,
    input  logic [rgbc_cal_pkg::CH_W-1:0]        raw_red,
    input  logic [rgbc_cal_pkg::CH_W-1:0]        raw_green,
    input  logic [rgbc_cal_pkg::CH_W-1:0]        raw_blue,
    output logic                                 work_valid,
    input  logic                                 work_ready,
    output rgbc_cal_pkg::work_t                  work
);
    import rgbc_cal_pkg::*;

    // settings
    logic [STEPS_W-1:0] steps_reg;
    logic               long_wait_reg;
    logic [1:0]         gain_idx_reg;
    logic               full_range_reg;

    // derived timing, registered from the settings in the cycle after they change
    logic [TIME_W-1:0]  time_reg;
    logic [TIME_W-1:0]  time_next;
    logic [TIME_W-1:0]  time_base;
    logic [SHIFT_W-1:0] gain_shift_reg;
    logic [SHIFT_W-1:0] gain_shift_next;

    // stage one
    logic                     s1_valid_reg;
    logic signed [CORR_W-1:0] s1_ir_reg;
    logic signed [CORR_W-1:0] s1_rc_reg;
    logic signed [CORR_W-1:0] s1_gc_reg;
    logic signed [CORR_W-1:0] s1_bc_reg;
    logic signed [CORR_W-1:0] s1_cc_reg;
    logic                     s1_rz_reg;
    logic                     s1_neg_reg;
    logic [MAG_W-1:0]         s1_mag_reg;

    // stage two
    logic  s2_valid_reg;
    work_t s2_reg;
    work_t s2_next;

    logic signed [SUM_W-1:0]  sum_w;
    logic signed [SUM_W-1:0]  sum_adj;
    logic signed [CORR_W-1:0] ir_w;
    logic [WSUM_W-1:0]        wsum_w;
    logic                     front_adv;
    logic [CPLX_W-1:0]        cpl_x_w;
    logic [CPL_PROD_W-1:0]    cpl_prod_w;

    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg      <= '0;
            long_wait_reg  <= 1'b0;
            gain_idx_reg   <= '0;
            full_range_reg <= 1'b1;
            time_reg       <= TIME_STEP_UNITS;
            gain_shift_reg <= SHIFT_W'(1);
        end
        else
        begin
            time_reg       <= time_next;
            gain_shift_reg <= gain_shift_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_INTEG_STEPS: steps_reg      <= cfg_data[STEPS_W-1:0];
                    REG_LONG_WAIT:   long_wait_reg  <= cfg_data[0];
                    REG_GAIN_INDEX:  gain_idx_reg   <= cfg_data[1:0];
                    REG_GAIN_RANGE:  full_range_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // integration time in units of 0.01 ms, and log2 of twice the gain
    always_comb
    begin
        time_base       = (TIME_W'(steps_reg) + TIME_W'(1)) * TIME_STEP_UNITS;
        time_next       = long_wait_reg ? time_base * LONG_WAIT_MULT : time_base;
        gain_shift_next = {gain_idx_reg, full_range_reg};
    end

    // infrared estimate, truncated toward zero, and the lux weighting
    always_comb
    begin
        sum_w   = $signed(SUM_W'(raw_red) + SUM_W'(raw_green) + SUM_W'(raw_blue)
                          - SUM_W'(raw_clear));
        sum_adj = sum_w + $signed(SUM_W'(sum_w[SUM_W-1]));
        ir_w    = sum_adj[SUM_W-1:1];
        wsum_w  = (WSUM_W'(raw_clear) << 4) - (WSUM_W'(raw_red) << 2)
                + (WSUM_W'(raw_green) << 4) - WSUM_W'(raw_blue) * BLUE_WEIGHT;
    end

    assign front_adv = !s2_valid_reg || work_ready;
    assign in_ready  = front_adv;

    // divider operands and the counts per lux estimate
    always_comb
    begin
        cpl_x_w            = CPLX_W'(time_reg) << gain_shift_reg;
        cpl_prod_w         = CPL_PROD_W'(cpl_x_w) * CPL_PROD_W'(CPL_RECIP);
        s2_next.infrared   = s1_ir_reg;
        s2_next.red_corr   = s1_rc_reg;
        s2_next.green_corr = s1_gc_reg;
        s2_next.blue_corr  = s1_bc_reg;
        s2_next.clear_corr = s1_cc_reg;
        s2_next.red_zero   = s1_rz_reg;
        s2_next.lux_neg    = s1_neg_reg;
        s2_next.lux_dvd    = DVD_W'(s1_mag_reg) * LUX_DVD_SCALE;
        s2_next.lux_dvs    = DVS_W'(time_reg) * LUX_DVS_SCALE;
        s2_next.cpl_x      = cpl_x_w;
        s2_next.cpl_est    = cpl_prod_w[RECIP_SHIFT +: CPLQ_W];
        s2_next.gain_shift = gain_shift_reg;
        s2_next.cct_num    = OUT_W'(s1_bc_reg) * CCT_BLUE_GAIN
                           + OUT_W'(s1_rc_reg) * CCT_OFFSET;
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (front_adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (front_adv)
        begin
            s1_ir_reg  <= ir_w;
            s1_rc_reg  <= $signed(CORR_W'(raw_red)) - ir_w;
            s1_gc_reg  <= $signed(CORR_W'(raw_green)) - ir_w;
            s1_bc_reg  <= $signed(CORR_W'(raw_blue)) - ir_w;
            s1_cc_reg  <= $signed(CORR_W'(raw_clear)) - ir_w;
            s1_rz_reg  <= ($signed(CORR_W'(raw_red)) == ir_w);
            s1_neg_reg <= wsum_w[WSUM_W-1];
            s1_mag_reg <= wsum_w[WSUM_W-1] ? MAG_W'(-wsum_w) : MAG_W'(wsum_w);
            s2_reg     <= s2_next;
        end
    end

    assign work_valid = s2_valid_reg;
    assign work       = s2_reg;

endmodule

>>> rtl/core/rgbc_cal_queue.sv
// ----------------------------------------------------------------------------
// rgbc calibrator queue
// two-word fifo between the front end and the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgbc_cal_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  rgbc_cal_pkg::work_t push_word,
    output logic                pop_valid,
    input  logic                pop,
    output rgbc_cal_pkg::work_t pop_word
);
    import rgbc_cal_pkg::*;

    work_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_word   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

>>> rtl/core/rgbc_cal_div.sv
// ----------------------------------------------------------------------------
// rgbc calibrator divider
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgbc_cal_div (
    input  logic                             clk,
    input  logic                             en,
    input  logic [rgbc_cal_pkg::DVD_W-1:0]   dividend,
    input  logic [rgbc_cal_pkg::DVS_W-1:0]   divisor,
    output logic [rgbc_cal_pkg::DVD_W-1:0]   quotient
);
    import rgbc_cal_pkg::*;

    logic [DVS_W-1:0] rem_reg  [DIV_STAGES];
    logic [DVD_W-1:0] dq_reg   [DIV_STAGES];
    logic [DVS_W-1:0] dvs_reg  [DIV_STAGES];
    logic [DVS_W-1:0] rem_next [DIV_STAGES];
    logic [DVD_W-1:0] dq_next  [DIV_STAGES];
    logic [DVS_W-1:0] dvs_next [DIV_STAGES];

    // one shift, compare and subtract per stage
    always_comb
    begin
        logic [DVS_W-1:0] rem_in;
        logic [DVD_W-1:0] dq_in;
        logic [DVS_W:0]   trial;
        logic             ge;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                rem_in      = '0;
                dq_in       = dividend;
                dvs_next[k] = divisor;
            end
            else
            begin
                rem_in      = rem_reg[k-1];
                dq_in       = dq_reg[k-1];
                dvs_next[k] = dvs_reg[k-1];
            end
            trial       = {rem_in, dq_in[DVD_W-1]};
            ge          = (trial >= {1'b0, dvs_next[k]});
            rem_next[k] = ge ? DVS_W'(trial - {1'b0, dvs_next[k]}) : trial[DVS_W-1:0];
            dq_next[k]  = {dq_in[DVD_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                rem_reg[k] <= rem_next[k];
                dq_reg[k]  <= dq_next[k];
                dvs_reg[k] <= dvs_next[k];
            end
        end
    end

    assign quotient = dq_reg[DIV_STAGES-1];

endmodule

>>> rtl/core/rgbc_cal_back.sv
// ----------------------------------------------------------------------------
// rgbc calibrator back end
// finishes counts per lux, runs the lux and cct divisions, forms the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgbc_cal_back (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       work_valid,
    output logic                                       work_pop,
    input  rgbc_cal_pkg::work_t                        work,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic signed [rgbc_cal_pkg::CORR_W-1:0]     infrared,
    output logic signed [rgbc_cal_pkg::CORR_W-1:0]     red_corrected,
    output logic signed [rgbc_cal_pkg::CORR_W-1:0]     green_corrected,
    output logic signed [rgbc_cal_pkg::CORR_W-1:0]     blue_corrected,
    output logic signed [rgbc_cal_pkg::CORR_W-1:0]     clear_corrected,
    output logic [rgbc_cal_pkg::OUT_W-1:0]             counts_per_lux,
    output logic signed [rgbc_cal_pkg::OUT_W-1:0]      lux,
    output logic signed [rgbc_cal_pkg::OUT_W-1:0]      colour_temp,
    output logic                                       red_zero
);
    import rgbc_cal_pkg::*;

    logic                 adv;
    logic                 v_reg    [DIV_STAGES];
    side_t                side_reg [DIV_STAGES];
    side_t                side_in;
    side_t                side_last;
    logic [OUT_W-1:0]     cct_mag_in;
    logic [DVS_W-1:0]     rc_mag_in;
    logic [CPL_NUM_W-1:0] cpl_hi;
    logic [DVD_W-1:0]     lux_q;
    logic [DVD_W-1:0]     cct_q;
    logic [OUT_W-1:0]     lux_mag;
    logic [OUT_W-1:0]     cct_mag;

    // output register frees the pipe when empty or taken
    logic out_valid_reg;
    assign adv       = !out_valid_reg || out_ready;
    assign work_pop  = adv && work_valid;
    assign out_valid = out_valid_reg;

    // signs and magnitudes for the colour temperature division,
    // and the one-step fixup of the counts per lux estimate
    always_comb
    begin
        cpl_hi = (CPL_NUM_W'(work.cpl_est) + CPL_NUM_W'(1)) * CPL_NUM_W'(CPL_DENOM);
        side_in.infrared   = work.infrared;
        side_in.red_corr   = work.red_corr;
        side_in.green_corr = work.green_corr;
        side_in.blue_corr  = work.blue_corr;
        side_in.clear_corr = work.clear_corr;
        side_in.red_zero   = work.red_zero;
        side_in.lux_neg    = work.lux_neg;
        side_in.cct_neg    = work.cct_num[OUT_W-1] ^ work.red_corr[CORR_W-1];
        side_in.cpl        = (cpl_hi <= {work.cpl_x, {CPL_FRAC{1'b0}}})
                           ? OUT_W'(work.cpl_est) + OUT_W'(1) : OUT_W'(work.cpl_est);
        side_in.gain_shift = work.gain_shift;
        cct_mag_in = work.cct_num[OUT_W-1] ? OUT_W'(-work.cct_num) : OUT_W'(work.cct_num);
        rc_mag_in  = work.red_corr[CORR_W-1] ? DVS_W'(-work.red_corr)
                                             : DVS_W'(work.red_corr);
    end

    rgbc_cal_div u_div_lux (
        .clk      (clk),
        .en       (adv),
        .dividend (work.lux_dvd),
        .divisor  (work.lux_dvs),
        .quotient (lux_q)
    );

    rgbc_cal_div u_div_cct (
        .clk      (clk),
        .en       (adv),
        .dividend (DVD_W'(cct_mag_in)),
        .divisor  (rc_mag_in),
        .quotient (cct_q)
    );

    // valid bits alongside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= work_valid;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // side fields alongside the dividers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // gain factor comes out as a shift, then signs go back on
    always_comb
    begin
        side_last = side_reg[DIV_STAGES-1];
        lux_mag   = OUT_W'(lux_q >> side_last.gain_shift);
        cct_mag   = OUT_W'(cct_q);
    end

    // result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= v_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            infrared        <= side_last.infrared;
            red_corrected   <= side_last.red_corr;
            green_corrected <= side_last.green_corr;
            blue_corrected  <= side_last.blue_corr;
            clear_corrected <= side_last.clear_corr;
            red_zero        <= side_last.red_zero;
            counts_per_lux  <= side_last.cpl;
            lux             <= side_last.lux_neg ? $signed(-lux_mag) : $signed(lux_mag);
            if (side_last.red_zero)
            begin
                colour_temp <= '0;
            end
            else
            begin
                colour_temp <= side_last.cct_neg ? $signed(-cct_mag) : $signed(cct_mag);
            end
        end
    end

endmodule

>>> rtl/core/rgbc_cal_checker.sv
// ----------------------------------------------------------------------------
// rgbc calibrator checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rgbc_lux_cct_calibrator_assert.svh"

module rgbc_cal_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   out_valid,
    input logic                                   out_ready,
    input logic signed [rgbc_cal_pkg::CORR_W-1:0] red_corrected,
    input logic [rgbc_cal_pkg::OUT_W-1:0]         counts_per_lux,
    input logic signed [rgbc_cal_pkg::OUT_W-1:0]  colour_temp,
    input logic                                   red_zero
);
    import rgbc_cal_pkg::*;

    // a held word stays offered
    `RGBC_CAL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // zero red forces the colour temperature to zero
    `RGBC_CAL_ASSERT_IMPL(a_cct_zero, out_valid && red_zero, colour_temp == '0)

    // the flag follows the corrected red it travels with
    `RGBC_CAL_ASSERT_IMPL(a_rz_match, out_valid, red_zero == (red_corrected == '0))

    // half unit gain never drives counts per lux to zero
    `RGBC_CAL_ASSERT_IMPL(a_cpl_pos, out_valid, counts_per_lux != '0)

endmodule

bind rgbc_lux_cct_calibrator rgbc_cal_checker u_checker (.*);

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// rgbc calibrator testbench
// drives raw sample words under random gaps and output stalls, walks the
// register settings between phases and checks every result word field by
// field against an in-bench model of the ir, counts per lux, lux and cct arithmetic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import rgbc_cal_pkg::*;

    // result word as predicted
    typedef struct {
        logic signed [CORR_W-1:0] ir;
        logic signed [CORR_W-1:0] rc;
        logic signed [CORR_W-1:0] gc;
        logic signed [CORR_W-1:0] bc;
        logic signed [CORR_W-1:0] cc;
        logic [OUT_W-1:0]         cpl;
        logic signed [OUT_W-1:0]  lux_q4;
        logic signed [OUT_W-1:0]  cct;
        logic                     rz;
    } cal_word_t;

    // directed row: raw channels plus hand-worked values where obvious
    typedef struct {
        logic [CH_W-1:0]          c, r, g, b;
        bit                       typed;
        logic signed [CORR_W-1:0] ir;
        logic                     rz;
        logic signed [OUT_W-1:0]  cct;
        logic [OUT_W-1:0]         cpl;
    } sample_row_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [CH_W-1:0] raw_clear, raw_red, raw_green, raw_blue;
    logic out_valid;
    logic out_ready;
    logic signed [CORR_W-1:0] infrared, red_corrected, green_corrected;
    logic signed [CORR_W-1:0] blue_corrected, clear_corrected;
    logic [OUT_W-1:0] counts_per_lux;
    logic signed [OUT_W-1:0] lux, colour_temp;
    logic red_zero;

    // shadow of the calibration registers
    logic [7:0] integ_steps;
    logic       long_wait_on;
    logic [1:0] gain_sel;
    logic       full_range;

    cal_word_t   pending_words[$];
    int          mismatches;
    bit          stim_done;
    sample_row_t sample_rows[12];

    rgbc_lux_cct_calibrator uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .raw_clear(raw_clear), .raw_red(raw_red),
        .raw_green(raw_green), .raw_blue(raw_blue),
        .out_valid(out_valid), .out_ready(out_ready),
        .infrared(infrared), .red_corrected(red_corrected),
        .green_corrected(green_corrected), .blue_corrected(blue_corrected),
        .clear_corrected(clear_corrected), .counts_per_lux(counts_per_lux),
        .lux(lux), .colour_temp(colour_temp), .red_zero(red_zero)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #50ms;
        $display("rgbc_lux_cct_calibrator verification failed");
        $finish;
    end

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // ir correction, counts per lux, lux and cct for one sample
    function automatic cal_word_t calibrate(input logic [CH_W-1:0] c16, r16, g16, b16);
        cal_word_t w;
        longint c, r, g, b, ir, num, cpl, s, lx, cct;
        c = longint'(c16);
        r = longint'(r16);
        g = longint'(g16);
        b = longint'(b16);
        ir = (r + g + b - c) / 2;
        num = longint'(1) << (2 * gain_sel);
        if (full_range)
            num = num * 2;
        num = num * 281 * (longint'(integ_steps) + 1);
        if (long_wait_on)
            num = num * 12;
        cpl = (num * 65536) / 136570;
        if (cpl > 64'sd4294967295)
            cpl = 64'sd4294967295;
        s = 16 * c - 4 * r + 16 * g - 29 * b;
        lx = sat32((s * 136570 * 16) / (num * 100));
        w.ir = CORR_W'(ir);
        w.rc = CORR_W'(r - ir);
        w.gc = CORR_W'(g - ir);
        w.bc = CORR_W'(b - ir);
        w.cc = CORR_W'(c - ir);
        w.cpl = OUT_W'(cpl);
        w.lux_q4 = OUT_W'(lx);
        if (r - ir == 0)
        begin
            w.rz = 1'b1;
            w.cct = '0;
        end
        else
        begin
            cct = sat32((4520 * (b - ir) + 1804 * (r - ir)) / (r - ir));
            w.rz = 1'b0;
            w.cct = OUT_W'(cct);
        end
        return w;
    endfunction

    // short gaps mostly, now and then a long one
    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    function automatic logic [CH_W-1:0] pick_channel();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return CH_W'($urandom_range(255));
            default: return CH_W'($urandom);
        endcase
    endfunction

    task automatic wait_cycles(input int n);
        repeat (n) @(negedge clk);
    endtask

    // one register word, accepted on cfg handshake; caller drops valid
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_INTEG_STEPS: integ_steps  = val;
            REG_LONG_WAIT:   long_wait_on = val[0];
            REG_GAIN_INDEX:  gain_sel     = val[1:0];
            REG_GAIN_RANGE:  full_range   = val[0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // pipeline empty and quiet before touching registers
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge clk);
        wait_cycles(60);
    endtask

    // one sample word, expectation queued on acceptance; valid stays up
    // into the next word unless a gap follows
    task automatic send_sample(input logic [CH_W-1:0] c, r, g, b, input bit typed,
                               input sample_row_t row);
        cal_word_t w;
        int        gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            wait_cycles(gap);
        end
        in_valid  <= 1'b1;
        raw_clear <= c;
        raw_red   <= r;
        raw_green <= g;
        raw_blue  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        w = calibrate(c, r, g, b);
        if (typed)
        begin
            w.ir  = row.ir;
            w.rz  = row.rz;
            w.cct = row.cct;
            w.cpl = row.cpl;
        end
        pending_words.push_back(w);
        @(negedge clk);
    endtask

    task automatic send_random(input int count, input int hold_at);
        logic [CH_W-1:0] c, r, g, b;
        longint cv;
        sample_row_t nil;
        nil = '{default: '0};
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
            begin
                in_valid <= 1'b0;
                while (pending_words.size() != 0)
                    @(negedge clk);
            end
            r = pick_channel();
            g = pick_channel();
            b = pick_channel();
            c = pick_channel();
            // steer some samples onto zero corrected red
            if ($urandom_range(9) == 0)
            begin
                cv = longint'(g) + longint'(b) - longint'(r);
                if (cv >= 0 && cv <= 65535)
                    c = CH_W'(cv);
            end
            send_sample(c, r, g, b, 1'b0, nil);
        end
    endtask

    // output stall pattern
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = pick_gap();
            if ($urandom_range(3) == 0 && stall > 0)
            begin
                out_ready <= 1'b0;
                wait_cycles(stall);
            end
            out_ready <= 1'b1;
            wait_cycles($urandom_range(8));
        end
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin
        cal_word_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word at %0t", $realtime);
            end
            else
            begin
                e = pending_words.pop_front();
                if (infrared !== e.ir || red_corrected !== e.rc
                    || green_corrected !== e.gc || blue_corrected !== e.bc
                    || clear_corrected !== e.cc || counts_per_lux !== e.cpl
                    || lux !== e.lux_q4 || colour_temp !== e.cct
                    || red_zero !== e.rz)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch at %0t: ir %0d/%0d rc %0d/%0d gc %0d/%0d ",
                                  "bc %0d/%0d cc %0d/%0d cpl %0d/%0d lux %0d/%0d ",
                                  "cct %0d/%0d rz %0b/%0b (exp/got)"}, $realtime,
                                 e.ir, infrared, e.rc, red_corrected, e.gc,
                                 green_corrected, e.bc, blue_corrected, e.cc,
                                 clear_corrected, e.cpl, counts_per_lux, e.lux_q4, lux,
                                 e.cct, colour_temp, e.rz, red_zero);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        logic [7:0] steps_set;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_INTEG_STEPS;
        cfg_data  = '0;
        in_valid  = 1'b0;
        raw_clear = '0;
        raw_red   = '0;
        raw_green = '0;
        raw_blue  = '0;
        mismatches = 0;
        stim_done  = 1'b0;
        integ_steps  = 8'd0;
        long_wait_on = 1'b0;
        gain_sel     = 2'd0;
        full_range   = 1'b1;

        // directed samples; reset settings give 269 counts per lux
        sample_rows[0]  = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 0, 1, 0, 269};
        sample_rows[1]  = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 65535, 1, 0, 269};
        sample_rows[2]  = '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1, -32767, 0, 6324, 269};
        sample_rows[3]  = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 98302, 0, 6324, 269};
        sample_rows[4]  = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 0, 0, 0, 0, 0};
        sample_rows[5]  = '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 0, 0, 0, 0, 0};
        sample_rows[6]  = '{16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 0, 0, 0, 0, 0};
        sample_rows[7]  = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 0, 0, 0, 0, 0};
        sample_rows[8]  = '{16'h0001, 16'h0001, 16'h0000, 16'h0001, 0, 0, 0, 0, 0};
        sample_rows[9]  = '{16'h1234, 16'h0100, 16'h1000, 16'h0334, 0, 0, 0, 0, 0};
        sample_rows[10] = '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 0, 0, 0, 0, 0};
        sample_rows[11] = '{16'h0000, 16'h0002, 16'h0001, 16'h0000, 0, 0, 0, 0, 0};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait_cycles(2);

        foreach (sample_rows[i])
            send_sample(sample_rows[i].c, sample_rows[i].r, sample_rows[i].g,
                        sample_rows[i].b, sample_rows[i].typed, sample_rows[i]);

        // register phases, extremes first, then random settings
        for (int ph = 0; ph < 9; ph++)
        begin
            drain();
            case (ph)
                0: steps_set = 8'd0;
                1: steps_set = 8'd255;
                default: steps_set = 8'($urandom);
            endcase
            write_reg(REG_INTEG_STEPS, steps_set);
            write_reg(REG_LONG_WAIT,
                      ph == 1 ? 8'hFF : (ph == 0 ? 8'h00 : CFG_DATA_W'($urandom)));
            write_reg(REG_GAIN_INDEX,
                      ph == 1 ? 8'h03 : (ph == 0 ? 8'hFC : CFG_DATA_W'($urandom)));
            write_reg(REG_GAIN_RANGE,
                      ph == 1 ? 8'h01 : (ph == 0 ? 8'hFE : CFG_DATA_W'($urandom)));
            cfg_valid <= 1'b0;
            send_random(182, ph == 4 ? 90 : -1);
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // end of run
    initial
    begin
        wait (stim_done);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("rgbc_lux_cct_calibrator verification clean");
        else
            $display("rgbc_lux_cct_calibrator verification failed");
        $finish;
    end

endmodule
